// ===== rtl/core/akeq_pkg.sv =====
// Shared types, constants and register codes of the analog keypad event queue.
`timescale 1ns / 1ps
package akeq_pkg;

  localparam int NUM_BTN   = 5;
  localparam int BTN_W     = 3;
  localparam int SAMPLE_W  = 10;
  localparam int LEVEL_W   = 10;
  localparam int MARGIN_W  = 8;
  localparam int MS_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int COUNT_W   = 3;

  localparam int DEF_QUEUE_DEPTH      = 5;
  localparam int DEF_SAMPLE_PERIOD_MS = 20;
  localparam int DEF_ADC_BITS         = 10;
  localparam int DEF_TIME_BITS        = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_RIGHT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_UP     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_DOWN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_LEFT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_SELECT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_MARGIN = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT       = 3'd7;

  localparam logic [LEVEL_W-1:0]  RST_LEVEL_RIGHT  = 10'd0;
  localparam logic [LEVEL_W-1:0]  RST_LEVEL_UP     = 10'd145;
  localparam logic [LEVEL_W-1:0]  RST_LEVEL_DOWN   = 10'd329;
  localparam logic [LEVEL_W-1:0]  RST_LEVEL_LEFT   = 10'd505;
  localparam logic [LEVEL_W-1:0]  RST_LEVEL_SELECT = 10'd741;
  localparam logic [MARGIN_W-1:0] RST_MATCH_MARGIN = 8'd25;
  localparam logic [MS_W-1:0]     RST_LONG_PRESS   = 16'd800;
  localparam logic [MS_W-1:0]     RST_REPEAT       = 16'd250;

  localparam logic [BTN_W-1:0] BTN_NONE = 3'd0;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EVK_PRESS  = 2'd0,
    EVK_SHORT  = 2'd1,
    EVK_LONG   = 2'd2,
    EVK_REPEAT = 2'd3
  } evk_e;

  typedef struct packed {
    logic [NUM_BTN-1:0][LEVEL_W-1:0] level;
    logic [MARGIN_W-1:0]             margin;
    logic [MS_W-1:0]                 long_ms;
    logic [MS_W-1:0]                 repeat_ms;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [BTN_W-1:0] btn;
  } cmd_t;

  typedef struct packed {
    evk_e             kind;
    logic [BTN_W-1:0] btn;
  } event_t;

  typedef struct packed {
    logic               event_valid;
    logic [BTN_W-1:0]   button;
    evk_e               event_kind;
    logic [COUNT_W-1:0] queue_count;
    logic               dropped;
  } res_t;

endpackage

// ===== rtl/core/analog_keypad_event_queue_unit.sv =====
// Top level of the resistor-ladder keypad decoder with auto-repeat event queue.
//
// Requests arrive on the s_axis stream: tuser carries the kind (millisecond
// tick, ADC sample or event read) and tdata carries the sample. Every request
// produces exactly one result on the m_axis stream, in request order.
// The front end matches the sample against the five button windows and places
// the classified request in a two-entry queue. The back end keeps time, button
// state and the event FIFO, and loads one result per cycle into the output
// register while results are taken, so one request per cycle is sustained.
// Each request is held in the queue before its result is registered.
// When the receiver stalls, the output register holds its result, the queue
// absorbs two more requests, and s_axis_tready then drops until results drain.
// Reset empties the queue and the event FIFO, clears time and button state,
// and loads the default button levels, margin and hold times.
// Registers are written through cfg_we_i, cfg_addr_i and cfg_wdata_i; the user
// must write them only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
module analog_keypad_event_queue_unit #(
  parameter int QUEUE_DEPTH      = akeq_pkg::DEF_QUEUE_DEPTH,
  parameter int SAMPLE_PERIOD_MS = akeq_pkg::DEF_SAMPLE_PERIOD_MS,
  parameter int ADC_BITS         = akeq_pkg::DEF_ADC_BITS,
  parameter int TIME_BITS        = akeq_pkg::DEF_TIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [akeq_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [akeq_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // sample[9:0], zero[15:10]
  input  logic [1:0]                      s_axis_tuser,  // kind[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // button[2:0], queue_count[5:3], dropped[6], zero[7]
  output logic [7:0]                      m_axis_tdata,
  output logic [2:0]                      m_axis_tuser   // event_valid[0], event_kind[2:1]
);
  import akeq_pkg::*;

  cfg_t cfg_q;
  logic q_push, q_ready, q_valid, q_pop;
  cmd_t q_in, q_out;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level[0]  <= RST_LEVEL_RIGHT;
      cfg_q.level[1]  <= RST_LEVEL_UP;
      cfg_q.level[2]  <= RST_LEVEL_DOWN;
      cfg_q.level[3]  <= RST_LEVEL_LEFT;
      cfg_q.level[4]  <= RST_LEVEL_SELECT;
      cfg_q.margin    <= RST_MATCH_MARGIN;
      cfg_q.long_ms   <= RST_LONG_PRESS;
      cfg_q.repeat_ms <= RST_REPEAT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_LEVEL_RIGHT:  cfg_q.level[0]  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_LEVEL_UP:     cfg_q.level[1]  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_LEVEL_DOWN:   cfg_q.level[2]  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_LEVEL_LEFT:   cfg_q.level[3]  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_LEVEL_SELECT: cfg_q.level[4]  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_MATCH_MARGIN: cfg_q.margin    <= cfg_wdata_i[MARGIN_W-1:0];
        CFG_LONG_PRESS:   cfg_q.long_ms   <= cfg_wdata_i[MS_W-1:0];
        CFG_REPEAT:       cfg_q.repeat_ms <= cfg_wdata_i[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  akeq_front #(
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .s_valid_i(s_axis_tvalid),
    .sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .kind_i   (s_axis_tuser),
    .cfg_i    (cfg_q),
    .q_ready_i(q_ready),
    .s_ready_o(s_axis_tready),
    .q_valid_o(q_push),
    .q_cmd_o  (q_in)
  );

  akeq_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(q_in),
    .ready_o   (q_ready),
    .valid_o   (q_valid),
    .pop_cmd_o (q_out),
    .pop_i     (q_pop)
  );

  akeq_back #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .SAMPLE_PERIOD_MS(SAMPLE_PERIOD_MS),
    .TIME_BITS       (TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_out),
    .cmd_pop_o  (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_res_o  (res),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, res.dropped, res.queue_count, res.button};
  assign m_axis_tuser = {res.event_kind, res.event_valid};

  a_no_lost_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> q_valid || m_axis_tvalid)
    else $error("accepted request left neither a queued command nor a result");

  a_empty_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.event_valid |-> res.button == BTN_NONE &&
      res.event_kind == EVK_PRESS)
    else $error("result without an event carries a button or kind");

  a_event_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.event_valid |-> res.button != BTN_NONE &&
      res.button <= BTN_W'(NUM_BTN))
    else $error("popped event names no valid button");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid && (!m_axis_tvalid || m_axis_tready))
    else $error("command taken while the result register was blocked");

endmodule

// ===== rtl/core/akeq_front.sv =====
// Front end: takes requests, classifies them and matches samples to buttons.
`timescale 1ns / 1ps
module akeq_front #(
  parameter int ADC_BITS = akeq_pkg::DEF_ADC_BITS
) (
  input  logic                          s_valid_i,
  input  logic [akeq_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [1:0]                    kind_i,
  input  akeq_pkg::cfg_t                cfg_i,
  input  logic                          q_ready_i,
  output logic                          s_ready_o,
  output logic                          q_valid_o,
  output akeq_pkg::cmd_t                q_cmd_o
);
  import akeq_pkg::*;

  localparam int EXT_W = 17;
  localparam logic [EXT_W-1:0] ADC_MAX = EXT_W'((1 << ADC_BITS) - 1);

  logic [BTN_W-1:0] match_btn;

  always_comb begin
    logic [EXT_W-1:0] lo;
    logic [EXT_W-1:0] hi;
    logic [EXT_W-1:0] smp;
    match_btn = BTN_NONE;
    smp = EXT_W'(sample_i);
    for (int i = NUM_BTN - 1; i >= 0; i--) begin
      lo = (cfg_i.level[i] > LEVEL_W'(cfg_i.margin)) ?
           EXT_W'(cfg_i.level[i] - LEVEL_W'(cfg_i.margin)) : '0;
      hi = EXT_W'(cfg_i.level[i]) + EXT_W'(cfg_i.margin);
      if (hi > ADC_MAX) begin
        hi = ADC_MAX;
      end
      if (smp >= lo && smp <= hi) begin
        match_btn = BTN_W'(i + 1);
      end
    end
  end

  assign s_ready_o     = q_ready_i;
  assign q_valid_o     = s_valid_i;
  assign q_cmd_o.kind  = kind_e'(kind_i);
  assign q_cmd_o.btn   = (kind_e'(kind_i) == KIND_SAMPLE) ? match_btn : BTN_NONE;

endmodule

// ===== rtl/core/akeq_cmd_fifo.sv =====
// Two-entry queue of classified requests between the front and back ends.
`timescale 1ns / 1ps
module akeq_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  akeq_pkg::cmd_t push_cmd_i,
  output logic           ready_o,
  output logic           valid_o,
  output akeq_pkg::cmd_t pop_cmd_o,
  input  logic           pop_i
);
  import akeq_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o   = (cnt_q != 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_cmd_o = mem_q[rd_q];
  assign do_push   = push_i && ready_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/core/akeq_back.sv =====
// Back end: timekeeping, button state, event FIFO and the result register.
`timescale 1ns / 1ps
module akeq_back #(
  parameter int QUEUE_DEPTH      = akeq_pkg::DEF_QUEUE_DEPTH,
  parameter int SAMPLE_PERIOD_MS = akeq_pkg::DEF_SAMPLE_PERIOD_MS,
  parameter int TIME_BITS        = akeq_pkg::DEF_TIME_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  akeq_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  akeq_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  output akeq_pkg::res_t out_res_o,
  input  logic           out_ready_i
);
  import akeq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]     DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [TIME_BITS-1:0] PERIOD   = TIME_BITS'(SAMPLE_PERIOD_MS);

  logic [TIME_BITS-1:0]              time_q, time_d, last_q, last_d;
  logic [NUM_BTN-1:0]                pressed_q, pressed_d;
  logic [NUM_BTN-1:0][TIME_BITS-1:0] press_q, press_d, rep_q, rep_d;
  event_t                            store_q [QUEUE_DEPTH];
  event_t                            store_d [QUEUE_DEPTH];
  logic [IDX_W-1:0]                  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic                              out_valid_q;
  res_t                              res_q, res_d;
  logic                              take;

  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign take        = cmd_pop_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    logic [TIME_BITS-1:0] held;
    logic [TIME_BITS-1:0] since;
    logic                 on;
    logic                 ev;
    evk_e                 ek;
    logic                 lost;
    event_t               head;
    time_d    = time_q;
    last_d    = last_q;
    pressed_d = pressed_q;
    press_d   = press_q;
    rep_d     = rep_q;
    store_d   = store_q;
    wr_d      = wr_q;
    rd_d      = rd_q;
    cnt_d     = cnt_q;
    lost      = 1'b0;
    head      = store_q[rd_q];
    held      = '0;
    since     = '0;
    on        = 1'b0;
    ev        = 1'b0;
    ek        = EVK_PRESS;
    res_d     = '0;
    res_d.event_kind = EVK_PRESS;
    unique case (cmd_i.kind)
      KIND_TICK: begin
        time_d = time_q + TIME_BITS'(1);
      end
      KIND_SAMPLE: begin
        if ((time_q - last_q) >= PERIOD) begin
          last_d = time_q;
          for (int i = 0; i < NUM_BTN; i++) begin
            on    = (cmd_i.btn == BTN_W'(i + 1));
            held  = time_q - press_q[i];
            since = time_q - rep_q[i];
            ev    = 1'b0;
            ek    = EVK_PRESS;
            if (pressed_q[i] != on) begin
              ev = 1'b1;
              if (on) begin
                press_d[i] = time_q;
                rep_d[i]   = time_q;
              end else begin
                ek = (held > TIME_BITS'(cfg_i.long_ms)) ? EVK_LONG : EVK_SHORT;
              end
              pressed_d[i] = on;
            end else if (on && held > TIME_BITS'(cfg_i.long_ms) &&
                         since > TIME_BITS'(cfg_i.repeat_ms)) begin
              ev       = 1'b1;
              ek       = EVK_REPEAT;
              rep_d[i] = time_q;
            end
            if (ev) begin
              if (cnt_d < DEPTH_C) begin
                store_d[wr_d].kind = ek;
                store_d[wr_d].btn  = BTN_W'(i + 1);
                cnt_d = cnt_d + CNT_W'(1);
                wr_d  = (wr_d == LAST_IDX) ? '0 : wr_d + IDX_W'(1);
              end else begin
                lost = 1'b1;
              end
            end
          end
        end
      end
      KIND_READ: begin
        if (cnt_q != '0) begin
          res_d.event_valid = 1'b1;
          res_d.button      = head.btn;
          res_d.event_kind  = head.kind;
          cnt_d = cnt_q - CNT_W'(1);
          rd_d  = (rd_q == LAST_IDX) ? '0 : rd_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
    res_d.queue_count = COUNT_W'(cnt_d);
    res_d.dropped     = lost;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      last_q      <= '0;
      pressed_q   <= '0;
      press_q     <= '0;
      rep_q       <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        time_q    <= time_d;
        last_q    <= last_d;
        pressed_q <= pressed_d;
        press_q   <= press_d;
        rep_q     <= rep_d;
        wr_q      <= wr_d;
        rd_q      <= rd_d;
        cnt_q     <= cnt_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      store_q <= store_d;
      res_q   <= res_d;
    end
  end

endmodule
